>>> hw/rtl/rirs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rirs_pkg - shared types and constants of the rejection sampler
// Field widths, status codes, register indexes and the per-draw result record.
// ----------------------------------------------------------------------------
package rirs_pkg;

  localparam int WORD_W  = 64;   // raw random word
  localparam int BOUND_W = 63;   // bound register and result value
  localparam int ROOM_W  = 7;    // room_bits register
  localparam int CNT_W   = 7;    // attempt counter
  localparam int STAT_W  = 2;

  localparam int MAX_ATTEMPTS_DEF = 100;
  localparam int WORD_BITS_DEF    = 64;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_BOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_MANY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_SRC_FAIL   = 2'd3;

  // configuration register indexes
  localparam logic REG_BOUND = 1'b0;
  localparam logic REG_ROOM  = 1'b1;

  localparam logic [BOUND_W-1:0] BOUND_RST = 63'd1;
  localparam logic [ROOM_W-1:0]  ROOM_RST  = 7'd64;

  typedef struct packed {
    logic               emit;
    logic [BOUND_W-1:0] value;
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   cnt_nxt;
  } attempt_res_t;

endpackage

>>> hw/rtl/rirs_attempt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rirs_attempt - evaluation of one draw
// Masks the word to the bound's bit length (or one more bit with up to two
// bound subtractions), compares against the bound and decides the result.
// ----------------------------------------------------------------------------
module rirs_attempt
  import rirs_pkg::*;
#(
  parameter int MAX_ATTEMPTS = MAX_ATTEMPTS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic [BOUND_W-1:0] bound,
  input  logic [ROOM_W-1:0]  room_bits,
  input  logic [WORD_W-1:0]  word,
  input  logic               failed,
  input  logic [CNT_W-1:0]   cnt,
  output attempt_res_t       res
);

  localparam logic [WORD_W-1:0] WORD_MASK =
    (WORD_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << WORD_BITS) - WORD_W'(1));
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ATTEMPTS);

  logic [BOUND_W-1:0] m1, m2, m4, m8, m16, mask_n;
  logic [BOUND_W-1:0] two_below;
  logic [WORD_W-1:0]  mask64;
  logic [ROOM_W-1:0]  room_m1;
  logic               clear2, room_ok, wide;
  logic [WORD_W-1:0]  word_m, r_w, r_n, r_wide, r_sel;
  logic [WORD_W:0]    d1, d2;
  logic               ge1, ge2, below;
  logic [CNT_W-1:0]   cnt_inc;

  always_comb begin
    // smear the top set bit downward: mask of bits below the bit length
    m1     = bound | (bound >> 1);
    m2     = m1 | (m1 >> 2);
    m4     = m2 | (m2 >> 4);
    m8     = m4 | (m4 >> 8);
    m16    = m8 | (m8 >> 16);
    mask_n = m16 | (m16 >> 32);

    // the two positions just under the top bit
    two_below = (mask_n >> 1) & ~(mask_n >> 3);
    clear2    = (bound & two_below) == '0;

    // n < room_bits: room of 64 or more always wins, else bit room-1 of the mask is clear
    mask64  = {1'b0, mask_n};
    room_m1 = room_bits - ROOM_W'(1);
    room_ok = room_bits[ROOM_W-1] || ((room_bits != '0) && !mask64[room_m1[5:0]]);
    wide    = clear2 && room_ok;

    word_m = word & WORD_MASK;
    r_n    = word_m & {1'b0, mask_n};
    r_w    = word_m & {mask_n, 1'b1};

    // both subtractions side by side; borrow flags give the compares
    d1  = {1'b0, r_w} - {2'b00, bound};
    d2  = {1'b0, r_w} - {1'b0, bound, 1'b0};
    ge1 = !d1[WORD_W];
    ge2 = !d2[WORD_W];
    r_wide = ge2 ? d2[WORD_W-1:0] : (ge1 ? d1[WORD_W-1:0] : r_w);

    r_sel   = wide ? r_wide : r_n;
    below   = r_sel < {1'b0, bound};
    cnt_inc = cnt + CNT_W'(1);

    res.emit    = 1'b1;
    res.value   = '0;
    res.status  = ST_OK;
    res.cnt_nxt = '0;
    if (bound == '0) begin
      res.status = ST_ZERO_BOUND;
    end else if (bound == BOUND_W'(1)) begin
      res.status = ST_OK;
    end else if (failed) begin
      res.status = ST_SRC_FAIL;
    end else if (cnt_inc >= CNT_MAX) begin
      res.status = ST_TOO_MANY;
    end else if (below) begin
      res.value = r_sel[BOUND_W-1:0];
    end else begin
      // reject: no beat, keep the attempt
      res.emit    = 1'b0;
      res.cnt_nxt = cnt_inc;
    end
  end

endmodule

>>> hw/rtl/random_in_range_rejection_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_in_range_rejection_sampler_unit - uniform random value below a bound
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata: random_word  tuser: source_failed
//   out_    | out | out_tvalid/tready  | tdata: value        tuser: status
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One beat is accepted per cycle unless a stalled result holds the input stage;
// a draw is evaluated while it is registered in the input stage, and its result
// is loaded into the output register when that stage advances.
// A rejected draw leaves no output beat and only advances the attempt count.
// An output stall holds the result register and stalls the input stage only
// when the draw in it produces a result.
// Reset clears the attempt count and both stages, and loads bound=1, room=64.
// ----------------------------------------------------------------------------
module random_in_range_rejection_sampler_unit
  import rirs_pkg::*;
#(
  parameter int MAX_ATTEMPTS = MAX_ATTEMPTS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [WORD_W-1:0]  in_tdata,    // [63:0] random_word
  input  logic               in_tuser,    // [0] source_failed
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,   // [62:0] value, [63] zero
  output logic [STAT_W-1:0]  out_tuser,   // [1:0] status
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [BOUND_W-1:0] cfg_data
);

  logic [BOUND_W-1:0] bound_r;
  logic [ROOM_W-1:0]  room_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               s1_valid_r;
  logic [WORD_W-1:0]  s1_word_r;
  logic               s1_failed_r;
  logic               out_valid_r;
  logic [BOUND_W-1:0] out_value_r;
  logic [STAT_W-1:0]  out_status_r;
  attempt_res_t       res;
  logic               s1_adv;

  rirs_attempt #(
    .MAX_ATTEMPTS (MAX_ATTEMPTS),
    .WORD_BITS    (WORD_BITS)
  ) u_attempt (
    .bound     (bound_r),
    .room_bits (room_r),
    .word      (s1_word_r),
    .failed    (s1_failed_r),
    .cnt       (cnt_r),
    .res       (res)
  );

  // a draw that leaves no beat never waits on the output side
  assign s1_adv    = s1_valid_r && (!res.emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_value_r};
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= BOUND_RST;
      room_r  <= ROOM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOUND: bound_r <= cfg_data;
        REG_ROOM:  room_r  <= cfg_data[ROOM_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        cnt_r <= res.cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r   <= in_tdata;
      s1_failed_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  // the count never rests at the limit: reaching it forces a result
  a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(MAX_ATTEMPTS))
    else $error("attempt count reached the limit without a result");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error result carries a nonzero value");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.emit |=> out_valid_r && (cnt_r == '0))
    else $error("result not registered or count not cleared");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r && (cnt_r == '0))
    else $error("reset left control state set");

endmodule
